### src/run_length_compressor_macros.svh
// assertion macros for the run-length compressor checker
// depends on clk and arst_n being visible where a macro is used
`ifndef RUN_LENGTH_COMPRESSOR_MACROS_SVH
`define RUN_LENGTH_COMPRESSOR_MACROS_SVH

// same-cycle implication, quiet during reset
`define RLC_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rlc assertion failed");

// next-cycle implication, quiet during reset
`define RLC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rlc assertion failed");

`endif

### src/rlc_pkg.sv
// shared types and constants of the run-length compressor
// no dependencies
package rlc_pkg;

	localparam int COUNT_DIGITS_DEF = 5;
	localparam int TOTAL_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH      = 4;

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	typedef struct packed {
		logic [7:0] symbol;
		logic       stream_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_count_digit;
		logic        last_of_item;
		logic        stream_done;
		logic [31:0] total_length;
		logic        count_saturated;
	} out_beat_t;

	// one queued run: its symbol and flags, plus an optional single-symbol tail run
	typedef struct packed {
		logic [7:0] run_sym;
		logic       run_ovf;
		logic       has_tail;
		logic [7:0] tail_sym;
		logic       stream_end;
	} run_info_t;

	typedef enum logic [1:0] {
		PH_SYM,
		PH_DIGIT,
		PH_TAIL
	} back_phase_t;

endpackage

### src/rlc_front.sv
// front part: accepts input beats, tracks the open run, pushes closed runs
// depends on rlc_pkg
module rlc_front #(
	parameter int COUNT_DIGITS = rlc_pkg::COUNT_DIGITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  rlc_pkg::in_beat_t         item,
	output logic                      push,
	output rlc_pkg::run_info_t        rec_info,
	output logic [4*COUNT_DIGITS-1:0] rec_count
);

	localparam int CW = 4 * COUNT_DIGITS;

	logic [7:0]    sym_q;
	logic [CW-1:0] cnt_q;
	logic          active_q;
	logic          ovf_q;

	logic [CW-1:0] cnt_inc;
	logic          all_nines;
	logic          carry;
	logic          same;
	logic          changed;

	// bcd increment with ripple carry over the digits, held at all nines
	always_comb begin
		all_nines = 1'b1;
		carry     = 1'b1;
		cnt_inc   = cnt_q;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (cnt_q[4*i +: 4] != 4'd9) begin
				all_nines = 1'b0;
			end
			if (carry) begin
				if (cnt_q[4*i +: 4] >= 4'd9) begin
					cnt_inc[4*i +: 4] = 4'd0;
				end else begin
					cnt_inc[4*i +: 4] = cnt_q[4*i +: 4] + 4'd1;
					carry             = 1'b0;
				end
			end
		end
		if (all_nines) begin
			cnt_inc = cnt_q;
		end
	end

	assign same    = active_q && (item.symbol == sym_q);
	assign changed = active_q && !same;
	assign push    = accept && (changed || item.stream_end);

	always_comb begin
		rec_info.has_tail   = changed && item.stream_end;
		rec_info.tail_sym   = item.symbol;
		rec_info.stream_end = item.stream_end;
		priority if (changed) begin
			rec_info.run_sym = sym_q;
			rec_info.run_ovf = ovf_q;
			rec_count        = cnt_q;
		end else if (same) begin
			rec_info.run_sym = sym_q;
			rec_info.run_ovf = ovf_q || all_nines;
			rec_count        = cnt_inc;
		end else begin
			rec_info.run_sym = item.symbol;
			rec_info.run_ovf = 1'b0;
			rec_count        = CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q    <= '0;
			cnt_q    <= '0;
			active_q <= 1'b0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			priority if (item.stream_end) begin
				sym_q    <= '0;
				cnt_q    <= '0;
				active_q <= 1'b0;
				ovf_q    <= 1'b0;
			end else if (same) begin
				cnt_q <= cnt_inc;
				ovf_q <= ovf_q || all_nines;
			end else begin
				sym_q    <= item.symbol;
				cnt_q    <= CW'(1);
				active_q <= 1'b1;
				ovf_q    <= 1'b0;
			end
		end
	end

endmodule

### src/rlc_queue.sv
// small register queue of closed runs between front and back
// depends on rlc_pkg
module rlc_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wr_data,
	input  logic         pop,
	output logic [W-1:0] head,
	output logic         full,
	output logic         empty
);

	localparam int DEPTH = rlc_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [NW-1:0] fill_q;

	assign full  = (fill_q == NW'(DEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   fill_q <= fill_q + NW'(1);
				2'b01:   fill_q <= fill_q - NW'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### src/rlc_back.sv
// back part: turns queued runs into output bytes, counts bytes per stream
// depends on rlc_pkg
module rlc_back #(
	parameter int COUNT_DIGITS = rlc_pkg::COUNT_DIGITS_DEF,
	parameter int TOTAL_BITS   = rlc_pkg::TOTAL_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      empty,
	input  rlc_pkg::run_info_t        head_info,
	input  logic [4*COUNT_DIGITS-1:0] head_count,
	output logic                      pop,
	output logic                      result_valid,
	input  logic                      result_ready,
	output rlc_pkg::out_beat_t        result
);

	localparam int CW = 4 * COUNT_DIGITS;
	localparam int IW = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

	rlc_pkg::back_phase_t phase_q, phase_n;
	logic [IW-1:0]         idx_q, idx_n;
	logic [TOTAL_BITS-1:0] bw_q, bw_inc;
	logic                  out_valid_q;
	rlc_pkg::out_beat_t    out_q;

	logic          step;
	logic          final_byte;
	logic          done;
	logic [IW-1:0] msd;
	logic [3:0]    dig;
	logic [3:0]    dig_c;
	logic [7:0]    byte_n;
	logic          is_digit_n;
	logic          ovf_n;

	assign step = !empty && (!out_valid_q || result_ready);
	assign pop  = step && final_byte;
	assign done = final_byte && head_info.stream_end;

	// most significant nonzero digit
	always_comb begin
		msd = '0;
		for (int i = 0; i < COUNT_DIGITS; i++) begin
			if (head_count[4*i +: 4] != 4'd0) begin
				msd = IW'(i);
			end
		end
	end

	assign dig   = head_count[4*idx_q +: 4];
	assign dig_c = (dig > 4'd9) ? 4'd9 : dig;

	always_comb begin
		phase_n    = phase_q;
		idx_n      = idx_q;
		final_byte = 1'b0;
		byte_n     = head_info.run_sym;
		is_digit_n = 1'b0;
		ovf_n      = head_info.run_ovf;
		unique case (phase_q)
			rlc_pkg::PH_SYM: begin
				if (head_count != CW'(1)) begin
					phase_n = rlc_pkg::PH_DIGIT;
					idx_n   = msd;
				end else if (head_info.has_tail) begin
					phase_n = rlc_pkg::PH_TAIL;
				end else begin
					final_byte = 1'b1;
				end
			end
			rlc_pkg::PH_DIGIT: begin
				byte_n     = rlc_pkg::ASCII_ZERO + {4'd0, dig_c};
				is_digit_n = 1'b1;
				if (idx_q != '0) begin
					idx_n = idx_q - IW'(1);
				end else if (head_info.has_tail) begin
					phase_n = rlc_pkg::PH_TAIL;
				end else begin
					final_byte = 1'b1;
				end
			end
			rlc_pkg::PH_TAIL: begin
				byte_n     = head_info.tail_sym;
				ovf_n      = 1'b0;
				final_byte = 1'b1;
			end
			default: begin
				final_byte = 1'b1;
			end
		endcase
		if (final_byte) begin
			phase_n = rlc_pkg::PH_SYM;
		end
	end

	// saturating byte counter of the current stream
	assign bw_inc = (bw_q == '1) ? bw_q : bw_q + TOTAL_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= rlc_pkg::PH_SYM;
			idx_q       <= '0;
			bw_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				phase_q     <= phase_n;
				idx_q       <= idx_n;
				bw_q        <= done ? '0 : bw_inc;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_q.out_byte        <= byte_n;
			out_q.is_count_digit  <= is_digit_n;
			out_q.last_of_item    <= final_byte;
			out_q.stream_done     <= done;
			out_q.total_length    <= done ? 32'(bw_inc) : 32'd0;
			out_q.count_saturated <= ovf_n;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### src/run_length_compressor.sv
// top level of the run-length compressor with decimal run counts
// depends on rlc_pkg, rlc_front, rlc_queue, rlc_back
//
// takes one byte beat per cycle and emits each run as its symbol followed,
// for runs longer than one, by the bcd run count as ascii digits with no
// leading zeros; the final byte of a stream carries stream_done and the
// stream's output byte count. the front tracks the open run and accepts a
// beat in every cycle in which the run queue (4 entries) has room; a beat
// that closes a run costs one queue entry. the back drains one queued run
// at one output byte per cycle while result_ready allows (1 to
// COUNT_DIGITS + 2 bytes per run), so the input stalls only while the
// run queue is full. the first byte of a run passes through the run queue
// and the output register before it shows on result. no clearing pass
// after reset
module run_length_compressor #(
	parameter int COUNT_DIGITS = rlc_pkg::COUNT_DIGITS_DEF,
	parameter int TOTAL_BITS   = rlc_pkg::TOTAL_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  rlc_pkg::in_beat_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output rlc_pkg::out_beat_t result
);

	localparam int CW = 4 * COUNT_DIGITS;
	localparam int QW = $bits(rlc_pkg::run_info_t) + CW;

	// front to queue
	logic               accept;
	logic               push;
	rlc_pkg::run_info_t rec_info;
	logic [CW-1:0]      rec_count;

	// queue to back
	logic [QW-1:0]      head;
	rlc_pkg::run_info_t head_info;
	logic [CW-1:0]      head_count;
	logic               full;
	logic               empty;
	logic               pop;

	// a beat is taken whenever the queue can hold the run it may close
	assign item_ready = !full;
	assign accept     = item_valid && item_ready;

	rlc_front #(
		.COUNT_DIGITS(COUNT_DIGITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.item     (item),
		.push     (push),
		.rec_info (rec_info),
		.rec_count(rec_count)
	);

	rlc_queue #(
		.W(QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data({rec_info, rec_count}),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	// split the head entry back into run info and bcd count
	assign head_info  = rlc_pkg::run_info_t'(head[QW-1:CW]);
	assign head_count = head[CW-1:0];

	rlc_back #(
		.COUNT_DIGITS(COUNT_DIGITS),
		.TOTAL_BITS  (TOTAL_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.empty       (empty),
		.head_info   (head_info),
		.head_count  (head_count),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

### src/rlc_checker.sv
// port-level checks of the run-length compressor, bound to the top level
// depends on rlc_pkg and run_length_compressor_macros.svh
`include "run_length_compressor_macros.svh"

module rlc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_ready,
	input rlc_pkg::out_beat_t result
);

	// a stalled result beat holds
	`RLC_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// end of stream also ends the item
	`RLC_ASSERT_IMPLIES(a_done_last, result_valid && result.stream_done, result.last_of_item)

	// length shows only on the final byte
	`RLC_ASSERT_IMPLIES(a_len_zero, result_valid && !result.stream_done, result.total_length == 32'd0)

	// count digits are ascii decimal
	`RLC_ASSERT_IMPLIES(a_digit_ascii, result_valid && result.is_count_digit, (result.out_byte >= rlc_pkg::ASCII_ZERO) && (result.out_byte <= rlc_pkg::ASCII_NINE))

endmodule

bind run_length_compressor rlc_checker u_rlc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for run_length_compressor: a directed table, runs with multi-digit
// counts, then random streams under several idling mixes and a back-pressure burst
// depends on rlc_pkg and the run_length_compressor rtl
module tb_top;

	localparam int DIGITS = rlc_pkg::COUNT_DIGITS_DEF;
	localparam logic [4*DIGITS-1:0] ALL_NINES = {DIGITS{4'h9}};
	localparam logic [4*DIGITS-1:0] COUNT_ONE = (4*DIGITS)'(1);
	// cycles with no beat on either side before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// long receiver hold-off that should back the block up into its input
	localparam int HOLD_CYCLES = 300;

	// one row of the directed table; the last beat of a row carries fin
	typedef struct {
		logic [7:0]         sym;
		int                 reps;
		logic               fin;
		bit                 typed;
		rlc_pkg::out_beat_t want;
	} stim_row_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	rlc_pkg::in_beat_t  item;
	logic               result_valid;
	logic               result_ready;
	rlc_pkg::out_beat_t result;

	// idling mix, changed only between phases
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	// receiver hold-off, counted down by the receiver process
	int hold_left = 0;

	// results still owed by the block, oldest first
	rlc_pkg::out_beat_t owed_bytes[$];
	// results of the beat being predicted
	rlc_pkg::out_beat_t new_bytes[$];

	int items_sent = 0;
	int bytes_checked = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	// predictor state: the open run and the stream's output byte count
	logic [7:0]          cur_sym;
	logic [4*DIGITS-1:0] cur_count;
	bit                  run_open;
	bit                  run_sat;
	logic [31:0]         out_total;

	stim_row_t dir_rows[$];

	run_length_compressor uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	task automatic push_byte(logic [7:0] v, bit dig);
		rlc_pkg::out_beat_t r;
		// the stream byte count holds at its top value
		if (out_total != '1)
			out_total++;
		r = '0;
		r.out_byte = v;
		r.is_count_digit = dig;
		r.count_saturated = run_sat;
		new_bytes.insert(new_bytes.size(), r);
	endtask

	// the open run goes out as its symbol, then its count in ascii if above one
	task automatic emit_open_run();
		bit started;
		logic [3:0] d;
		started = 0;
		push_byte(cur_sym, 1'b0);
		if (cur_count != COUNT_ONE) begin
			for (int p = DIGITS - 1; p >= 0; p--) begin
				d = cur_count[4*p +: 4];
				if (d > 4'd9)
					d = 4'd9;
				// leading zeros are dropped, inner zeros kept
				if (d != 4'd0 || started) begin
					started = 1;
					push_byte(rlc_pkg::ASCII_ZERO + {4'd0, d}, 1'b1);
				end
			end
		end
	endtask

	task automatic open_new_run(logic [7:0] s);
		cur_sym = s;
		cur_count = COUNT_ONE;
		run_open = 1;
		run_sat = 0;
	endtask

	// bcd count plus one, pinned at all nines with the saturation flag set
	task automatic bump_count();
		logic [3:0] d;
		if (cur_count == ALL_NINES) begin
			run_sat = 1;
		end else begin
			for (int p = 0; p < DIGITS; p++) begin
				d = cur_count[4*p +: 4];
				if (d >= 4'd9) begin
					cur_count[4*p +: 4] = 4'h0;
				end else begin
					cur_count[4*p +: 4] = d + 4'd1;
					break;
				end
			end
		end
	endtask

	// works out the result beats caused by one accepted input beat
	task automatic predict_item(rlc_pkg::in_beat_t b);
		int tail_idx;
		new_bytes.delete();
		if (!run_open)
			open_new_run(b.symbol);
		else if (b.symbol == cur_sym)
			bump_count();
		else begin
			emit_open_run();
			open_new_run(b.symbol);
		end
		if (b.stream_end) begin
			emit_open_run();
			tail_idx = new_bytes.size() - 1;
			new_bytes[tail_idx].stream_done = 1'b1;
			new_bytes[tail_idx].total_length = out_total;
			// stream closed, next beat starts afresh
			run_open = 0;
			cur_sym = '0;
			cur_count = '0;
			run_sat = 0;
			out_total = '0;
		end
		if (new_bytes.size() > 0) begin
			tail_idx = new_bytes.size() - 1;
			new_bytes[tail_idx].last_of_item = 1'b1;
		end
	endtask

	// ---------------------------------------------------------------- sender

	// offers one beat, idling at random first; typed rows owe the given result
	task automatic send_item(logic [7:0] s, logic e, bit typed, rlc_pkg::out_beat_t want);
		rlc_pkg::in_beat_t b;
		b.symbol = s;
		b.stream_end = e;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		// hold the beat until the block takes it
		do @(posedge clk); while (!item_ready);
		predict_item(b);
		if (typed)
			owed_bytes.insert(owed_bytes.size(), want);
		else
			foreach (new_bytes[i])
				owed_bytes.insert(owed_bytes.size(), new_bytes[i]);
		items_sent++;
	endtask

	// drop valid and wait for every owed result
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (owed_bytes.size() != 0)
			@(posedge clk);
	endtask

	// random streams: mostly short runs over a small alphabet, some wide bytes,
	// now and then a run of 95 to 110 beats, long enough for two or three digits
	task automatic random_phase(int n_items);
		int sent_here;
		int len;
		int pick;
		logic [7:0] s;
		bit close_run;
		bit e;
		sent_here = 0;
		while (sent_here < n_items) begin
			pick = $urandom_range(99);
			if (pick < 55)
				len = 1;
			else if (pick < 85)
				len = $urandom_range(2, 4);
			else if (pick < 98)
				len = $urandom_range(5, 14);
			else
				len = $urandom_range(95, 110);
			if ($urandom_range(99) < 75)
				s = 8'($urandom_range(8'h61, 8'h64));
			else
				s = 8'($urandom_range(255));
			close_run = ($urandom_range(99) < 20);
			for (int k = 0; k < len && sent_here < n_items; k++) begin
				// stream ends at a run's end, at the phase end, or rarely mid-run
				e = (k == len - 1 && close_run) || sent_here == n_items - 1
					|| $urandom_range(99) < 2;
				send_item(s, e, 1'b0, '0);
				sent_here++;
			end
		end
	endtask

	// ---------------------------------------------------------------- receiver

	initial begin
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ---------------------------------------------------------------- checker

	task automatic check_field(string fname, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", fname, want_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : check_results
		rlc_pkg::out_beat_t want;
		if (arst_n && result_valid && result_ready) begin
			if (owed_bytes.size() == 0) begin
				$error("result beat with nothing owed: byte %0h", result.out_byte);
				mismatches++;
			end else begin
				want = owed_bytes.pop_front();
				check_field("out_byte", want.out_byte, result.out_byte);
				check_field("is_count_digit", want.is_count_digit, result.is_count_digit);
				check_field("last_of_item", want.last_of_item, result.last_of_item);
				check_field("stream_done", want.stream_done, result.stream_done);
				check_field("total_length", want.total_length, result.total_length);
				check_field("count_saturated", want.count_saturated,
					result.count_saturated);
				bytes_checked++;
			end
		end
	end

	// watchdog: too long with no beat on either side means the block hung
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results owed",
				idle_cycles, owed_bytes.size());
			$display("end of test: mismatches");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- main

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cur_sym = '0;
		cur_count = '0;
		run_open = 0;
		run_sat = 0;
		out_total = '0;

		// single-byte streams straight after reset give one plain symbol, total 1
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h00, 1, 1'b1, 1'b1,
			rlc_pkg::out_beat_t'{8'h00, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0}});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'hFF, 1, 1'b1, 1'b1,
			rlc_pkg::out_beat_t'{8'hFF, 1'b0, 1'b1, 1'b1, 32'd1, 1'b0}});
		// zero symbol repeated: same as the cleared run symbol
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h00, 1, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h00, 1, 1'b1, 1'b0, '0});
		// short run closed by the final byte
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h41, 2, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h41, 1, 1'b1, 1'b0, '0});
		// symbol change on the final byte: old run then the new lone symbol
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h55, 1, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'hAA, 1, 1'b1, 1'b0, '0});
		// digit-valued symbols and a count with an inner zero
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h30, 10, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h31, 1, 1'b1, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h37, 101, 1'b1, 1'b0, '0});
		// alternating high and low bits, every run a lone symbol
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h80, 1, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h7F, 1, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h80, 1, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h01, 1, 1'b1, 1'b0, '0});
		// all-ones symbol with a two-digit count, then a lone zero ends the stream
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'hFF, 20, 1'b0, 1'b0, '0});
		dir_rows.insert(dir_rows.size(), stim_row_t'{8'h00, 1, 1'b1, 1'b0, '0});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, no idling
		foreach (dir_rows[i])
			for (int k = 0; k < dir_rows[i].reps; k++)
				send_item(dir_rows[i].sym, dir_rows[i].fin && k == dir_rows[i].reps - 1,
					dir_rows[i].typed && k == dir_rows[i].reps - 1, dir_rows[i].want);
		drain();

		// random streams, no idling
		random_phase(70);
		drain();

		// back-pressure: receiver holds off while each beat after the first closes a run
		hold_left = HOLD_CYCLES;
		for (int i = 0; i < 40; i++)
			send_item(8'h10 + 8'(i * 7), i == 39, 1'b0, '0);
		drain();

		// sender idling
		send_idle_pct = 56;
		random_phase(70);
		drain();

		// receiver stalling
		send_idle_pct = 0;
		recv_stall_pct = 56;
		random_phase(70);
		drain();

		// both sides idling
		send_idle_pct = 24;
		recv_stall_pct = 24;
		random_phase(70);
		drain();

		// let any stray result show up
		repeat (10) @(posedge clk);

		$display("run covered %0d input beats and %0d checked result beats,", items_sent,
			bytes_checked);
		$display("including multi-digit counts, a long output stall and four idling mixes");
		if (mismatches == 0 && owed_bytes.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/rlc_pkg.sv
src/rlc_front.sv
src/rlc_queue.sv
src/rlc_back.sv
src/run_length_compressor.sv
src/rlc_checker.sv
bench/tb_top.sv
